// ===== hw/rtl/pae_pkg.sv =====
// ----------------------------------------------------------------------------
// pae_pkg
// Shared types and constants for the positional array editor.
// ----------------------------------------------------------------------------
package pae_pkg;

  localparam int OP_W         = 2;
  localparam int POS_W        = 5;
  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int IDX_W        = 4;
  localparam int MAX_RESULTS  = 16;
  localparam int DEF_CAPACITY = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TRAV
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic edit;
    logic trav_emit;
    logic empty_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            fill_empty;
    logic            trav_last;
    logic            out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/pae_if.sv =====
// ----------------------------------------------------------------------------
// pae_if
// Valid/ready channels for requests and results of the array editor.
// ----------------------------------------------------------------------------
interface pae_req_if
  import pae_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [POS_W-1:0]    position;
  logic signed [DATA_W-1:0] item;

  modport source (output valid, output op, output position, output item, input ready);
  modport sink   (input valid, input op, input position, input item, output ready);
endinterface

interface pae_rsp_if
  import pae_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] element;
  logic [IDX_W-1:0]         element_index;
  logic                     last;

  modport source (output valid, output status, output element, output element_index,
                  output last, input ready);
  modport sink   (input valid, input status, input element, input element_index,
                  input last, output ready);
endinterface

// ===== hw/rtl/pae_ctl.sv =====
// ----------------------------------------------------------------------------
// pae_ctl
// Controller state machine: sequences accept, edit and traverse steps.
// ----------------------------------------------------------------------------
module pae_ctl
  import pae_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_t'(stat.op))
          OP_INSERT, OP_DELETE: begin
            if (stat.out_free) begin
              cmd.edit   = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_TRAVERSE: begin
            if (stat.out_free) begin
              if (stat.fill_empty) begin
                cmd.empty_emit = 1'b1;
                state_next     = S_IDLE;
              end else begin
                cmd.trav_emit = 1'b1;
                state_next    = stat.trav_last ? S_IDLE : S_TRAV;
              end
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_TRAV: begin
        if (stat.out_free) begin
          cmd.trav_emit = 1'b1;
          if (stat.trav_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pae_dp.sv =====
// ----------------------------------------------------------------------------
// pae_dp
// Datapath: entry array with parallel shift, fill count, traverse counter
// and result register.
// ----------------------------------------------------------------------------
module pae_dp
  import pae_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic [OP_W-1:0]          req_op,
  input  logic [POS_W-1:0]         req_position,
  input  logic signed [DATA_W-1:0] req_item,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic [STATUS_W-1:0]      rsp_status,
  output logic signed [DATA_W-1:0] rsp_element,
  output logic [IDX_W-1:0]         rsp_element_index,
  output logic                     rsp_last
);

  localparam int FW         = $clog2(CAPACITY + 1);
  localparam int CW         = (FW > POS_W) ? FW : POS_W;
  localparam int TRAV_DEPTH = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
  localparam int TW         = $clog2(TRAV_DEPTH);
  localparam int NW         = $clog2(TRAV_DEPTH + 1);

  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         pos;
  logic signed [DATA_W-1:0] item;
  logic [FW-1:0]            fill;
  logic [TW-1:0]            tidx;
  logic [DATA_W-1:0]        entries   [CAPACITY];
  logic [DATA_W-1:0]        trav_view [TRAV_DEPTH];

  logic [CW-1:0]            posx;
  logic [CW-1:0]            fillx;
  logic                     full;
  logic                     do_insert;
  logic                     do_delete;
  status_t                  edit_status;
  logic [NW-1:0]            trav_n;
  logic                     out_free;

  assign posx     = CW'(pos);
  assign fillx    = CW'(fill);
  assign full     = (fill == FW'(CAPACITY));
  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    do_insert   = 1'b0;
    do_delete   = 1'b0;
    edit_status = ST_OK;
    case (op_t'(op))
      OP_INSERT: begin
        if (posx > fillx) begin
          edit_status = ST_BAD_POS;
        end else if (full) begin
          edit_status = ST_FULL;
        end else begin
          do_insert = cmd.edit;
        end
      end
      OP_DELETE: begin
        if (posx >= fillx) begin
          edit_status = ST_BAD_POS;
        end else begin
          do_delete = cmd.edit;
        end
      end
      default: begin
        edit_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= req_op;
      pos  <= req_position;
      item <= req_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (do_insert) begin
      fill <= fill + FW'(1);
    end else if (do_delete) begin
      fill <= fill - FW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (do_insert) begin
        if (CW'(i) == posx) begin
          entries[i] <= item;
        end else if (CW'(i) > posx) begin
          if (i > 0) begin
            entries[i] <= entries[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (do_delete) begin
        if (CW'(i) >= posx && i < CAPACITY - 1) begin
          entries[i] <= entries[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  for (genvar j = 0; j < TRAV_DEPTH; j++) begin : g_view
    assign trav_view[j] = entries[j];
  end

  assign trav_n = (fill > FW'(TRAV_DEPTH)) ? NW'(TRAV_DEPTH) : NW'(fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      tidx <= '0;
    end else if (cmd.load) begin
      tidx <= '0;
    end else if (cmd.trav_emit) begin
      tidx <= tidx + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.edit || cmd.trav_emit || cmd.empty_emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edit) begin
      rsp_status        <= edit_status;
      rsp_element       <= '0;
      rsp_element_index <= '0;
      rsp_last          <= 1'b1;
    end else if (cmd.empty_emit) begin
      rsp_status        <= ST_EMPTY;
      rsp_element       <= '0;
      rsp_element_index <= '0;
      rsp_last          <= 1'b1;
    end else if (cmd.trav_emit) begin
      rsp_status        <= ST_OK;
      rsp_element       <= trav_view[tidx];
      rsp_element_index <= IDX_W'(tidx);
      rsp_last          <= stat.trav_last;
    end
  end

  assign stat.op         = op;
  assign stat.fill_empty = (fill == '0);
  assign stat.trav_last  = ((NW'(tidx) + NW'(1)) == trav_n);
  assign stat.out_free   = out_free;

endmodule

// ===== hw/rtl/positional_array_editor.sv =====
// ----------------------------------------------------------------------------
// positional_array_editor
// Ordered array of signed words with insert and delete by position and an
// in-order traverse.
// ----------------------------------------------------------------------------
//  channel | role | payload
//  req     | sink | op, position, item
//  rsp     | src  | status, element, element_index, last
//
//  Insert and delete take the request in S_IDLE, then in S_EXEC shift
//  the entries at and above the position in parallel and load the result
//  register once it is free. Traverse emits one entry per cycle while rsp
//  is not stalled, through the single read of the traverse counter.
//  Reset clears the fill count, controller and result valid.
//  A stalled rsp holds the controller; a new request is taken while the
//  last result of the previous one still waits.
// ----------------------------------------------------------------------------
module positional_array_editor
  import pae_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic      clk,
  input logic      rst,
  pae_req_if.sink  req,
  pae_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pae_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pae_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .req_op            (req.op),
    .req_position      (req.position),
    .req_item          (req.item),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_element       (rsp.element),
    .rsp_element_index (rsp.element_index),
    .rsp_last          (rsp.last)
  );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the positional array editor. Drives insert, delete and
// traverse requests over the request channel, keeps a shadow copy of the
// array and fill count to predict every result, and checks each result
// transfer field by field in order. Both channels idle and stall at random,
// with one long receiver hold-off and one stretch with no idling at all.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pae_pkg::*;

  localparam int              CAP          = DEF_CAPACITY;
  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam int              CYCLE_LIMIT  = 200000;
  localparam int              DRAIN_CYCLES = 40;
  localparam int              IDLE_PCT     = 21;
  localparam int              HOLD_CYCLES  = 80;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] element;
    logic [IDX_W-1:0]         element_index;
    logic                     last;
  } edit_rsp_t;

  logic clk;
  logic rst;

  pae_req_if req ();
  pae_rsp_if rsp ();

  positional_array_editor #(.CAPACITY(CAP)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic signed [DATA_W-1:0] array_shadow [CAP];
  int                       fill_shadow;
  edit_rsp_t                pending_rsp [$];
  int                       mismatches  = 0;
  int                       cycle_count = 0;
  int                       hold_asks   = 0;
  int                       hold_left;
  bit                       gaps_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void expect_rsp(status_t st, logic signed [DATA_W-1:0] el,
                                     logic [IDX_W-1:0] idx, logic lst);
    edit_rsp_t r;
    r.status        = st;
    r.element       = el;
    r.element_index = idx;
    r.last          = lst;
    pending_rsp.push_back(r);
  endfunction

  function automatic void predict_edit(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                       logic signed [DATA_W-1:0] val);
    int i;
    int n;
    if (op == OP_INSERT) begin
      if (pos > fill_shadow) begin
        expect_rsp(ST_BAD_POS, '0, '0, 1'b1);
      end else if (fill_shadow >= CAP) begin
        expect_rsp(ST_FULL, '0, '0, 1'b1);
      end else begin
        for (i = fill_shadow; i > pos; i--) array_shadow[i] = array_shadow[i-1];
        array_shadow[pos] = val;
        fill_shadow++;
        expect_rsp(ST_OK, '0, '0, 1'b1);
      end
    end else if (op == OP_DELETE) begin
      if (pos >= fill_shadow) begin
        expect_rsp(ST_BAD_POS, '0, '0, 1'b1);
      end else begin
        for (i = pos; i + 1 < fill_shadow; i++) array_shadow[i] = array_shadow[i+1];
        fill_shadow--;
        expect_rsp(ST_OK, '0, '0, 1'b1);
      end
    end else if (op == OP_TRAVERSE) begin
      if (fill_shadow == 0) begin
        expect_rsp(ST_EMPTY, '0, '0, 1'b1);
      end else begin
        n = (fill_shadow > MAX_RESULTS) ? MAX_RESULTS : fill_shadow;
        for (i = 0; i < n; i++)
          expect_rsp(ST_OK, array_shadow[i], IDX_W'(i), (i + 1 == n));
      end
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.op       = op;
    req.position = pos;
    req.item     = val;
    req.valid    = 1'b1;
    do @(posedge clk); while (!req.ready);
    predict_edit(op, pos, val);
  endtask

  task automatic test_empty_array();
    send_request(OP_TRAVERSE, 5'd0, '0);
    send_request(OP_DELETE, 5'd0, 32'sh1234_5678);
    send_request(OP_DELETE, 5'd31, -1);
    send_request(OP_INSERT, 5'd1, 32'sh5555_aaaa);
    send_request(OP_UNUSED, 5'd31, -1);
  endtask

  task automatic test_fill_and_full();
    send_request(OP_INSERT, 5'd0, 32'sh7fff_ffff);
    send_request(OP_INSERT, 5'd1, 32'sh8000_0000);
    send_request(OP_INSERT, 5'd0, -1);
    send_request(OP_INSERT, 5'd1, '0);
    while (fill_shadow < CAP) send_request(OP_INSERT, POS_W'(fill_shadow), pick_value());
    send_request(OP_INSERT, 5'd16, 32'sh0f0f_0f0f);
    send_request(OP_INSERT, 5'd17, 32'sh0f0f_0f0f);
    send_request(OP_INSERT, 5'd0, 32'sh0f0f_0f0f);
    send_request(OP_TRAVERSE, 5'd31, -1);
    send_request(OP_DELETE, 5'd15, '0);
    send_request(OP_DELETE, 5'd0, '0);
    send_request(OP_DELETE, 5'd14, '0);
    send_request(OP_TRAVERSE, 5'd0, '0);
  endtask

  task automatic test_random_edits(int count, int ins_pct, int del_pct);
    int                       sent;
    int                       r;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    sent = 0;
    while (sent < count) begin
      r   = $urandom_range(99);
      val = pick_value();
      pos = POS_W'($urandom_range(31));
      if (r < 4) begin
        send_request(OP_UNUSED, pos, val);
      end else if (r < 4 + ins_pct) begin
        if ($urandom_range(99) >= 12) pos = POS_W'($urandom_range(fill_shadow));
        send_request(OP_INSERT, pos, val);
        sent++;
      end else if (r < 4 + ins_pct + del_pct) begin
        if (fill_shadow > 0 && $urandom_range(99) >= 12)
          pos = POS_W'($urandom_range(fill_shadow - 1));
        send_request(OP_DELETE, pos, val);
        sent++;
      end else begin
        send_request(OP_TRAVERSE, pos, val);
        sent++;
      end
    end
  endtask

  task automatic test_back_pressure();
    hold_asks++;
    test_random_edits(30, 40, 30);
  endtask

  task automatic test_no_idle();
    gaps_on = 1'b0;
    test_random_edits(60, 40, 35);
    gaps_on = 1'b1;
  endtask

  initial begin
    int hold_seen;
    hold_seen = 0;
    hold_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp.ready = 1'b0;
        hold_left--;
      end else begin
        rsp.ready = !(gaps_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    edit_rsp_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d element %0d index %0d last %0b",
                   rsp.status, rsp.element, rsp.element_index, rsp.last);
      end else begin
        exp_r = pending_rsp.pop_front();
        if (rsp.status !== exp_r.status || rsp.element !== exp_r.element ||
            rsp.element_index !== exp_r.element_index || rsp.last !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                     exp_r.status, exp_r.element, exp_r.element_index, exp_r.last,
                     rsp.status, rsp.element, rsp.element_index, rsp.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("positional_array_editor test failed");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    req.valid    = 1'b0;
    req.op       = '0;
    req.position = '0;
    req.item     = '0;
    fill_shadow  = 0;
    gaps_on      = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_array();
    test_fill_and_full();
    test_random_edits(180, 50, 30);
    test_back_pressure();
    test_random_edits(150, 35, 45);
    test_no_idle();

    @(negedge clk);
    req.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("positional_array_editor test passed");
    end else begin
      $display("positional_array_editor test failed");
    end
    $finish;
  end

endmodule
